FILE: sv/brse_pkg.sv
// Shared constants for the bitmap row span extractor.
// No dependencies; imported by bitmap_row_span_extractor.
package brse_pkg;

  // Pixel positions, widths and span coordinates are all one byte wide.
  localparam int unsigned PIX_W = 8;

  // Default number of runs recorded per row.
  localparam int unsigned MAX_RUNS_DEF = 5;

  // Number of start/end slot pairs in one row result.
  localparam int unsigned OUT_SLOTS = 5;

  // Row width after reset.
  localparam logic [PIX_W-1:0] GLYPH_WIDTH_RST = 8'd32;

endpackage

FILE: sv/bitmap_row_span_extractor.sv
// Bitmap row span extractor: top level, run tracking and row result register.
// Depends on brse_pkg for widths, slot count and reset constants.
//
//   Channel   Direction  Handshake              Word
//   in_       input      in_valid / in_ready    in_pixel_bit, one pixel of a row
//   out_      output     out_valid / out_ready  five start/end pairs and too_curvy
//   cfg_      input      cfg_wr_en, no wait     cfg_wr_data, the glyph width
//
// One pixel is taken per cycle unless in_ready is low. The last pixel of a row
// loads the result register at the same edge, so the word appears in the next cycle.
// Reset (rst_n low, synchronous) sets the width to 32 and empties the row state.
// A pending result only stalls the input when the next pixel would end a row.
module bitmap_row_span_extractor
  import brse_pkg::*;
#(
  parameter int unsigned MAX_RUNS = MAX_RUNS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             cfg_wr_en,
  input  logic [PIX_W-1:0] cfg_wr_data,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_pixel_bit,

  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_start_0,
  output logic [PIX_W-1:0] out_end_0,
  output logic [PIX_W-1:0] out_start_1,
  output logic [PIX_W-1:0] out_end_1,
  output logic [PIX_W-1:0] out_start_2,
  output logic [PIX_W-1:0] out_end_2,
  output logic [PIX_W-1:0] out_start_3,
  output logic [PIX_W-1:0] out_end_3,
  output logic [PIX_W-1:0] out_start_4,
  output logic [PIX_W-1:0] out_end_4,
  output logic             out_too_curvy
);

  // Run counter holds 0..MAX_RUNS; a run index holds 0..MAX_RUNS-1.
  localparam int unsigned CNT_W  = $clog2(MAX_RUNS + 1);
  localparam int unsigned RIDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  typedef logic [PIX_W-1:0] pix_t;

  // Configuration and row state.
  pix_t             width_r;
  pix_t             pos_r;
  logic [CNT_W-1:0] cnt_r;
  logic             inside_r;
  logic             ovf_r;
  pix_t             starts_r [MAX_RUNS];
  pix_t             ends_r   [MAX_RUNS];

  // Next values of the row state for the pixel on the input.
  logic [CNT_W-1:0] cnt_nxt;
  logic             inside_nxt;
  logic             ovf_nxt;
  pix_t             starts_nxt [MAX_RUNS];
  pix_t             ends_nxt   [MAX_RUNS];

  // Result register.
  logic             out_valid_r;
  pix_t             slot_start_r [OUT_SLOTS];
  pix_t             slot_end_r   [OUT_SLOTS];
  logic             too_curvy_r;
  pix_t             slot_start_nxt [OUT_SLOTS];
  pix_t             slot_end_nxt   [OUT_SLOTS];

  pix_t             width_eff;
  logic [PIX_W:0]   pos_inc;
  logic             row_end;
  logic             in_acc;
  logic [CNT_W-1:0] cnt_last;
  logic [CNT_W-1:0] cnt_nxt_last;

  // A width of zero behaves as a width of one.
  assign width_eff = (width_r == '0) ? pix_t'(1) : width_r;
  assign pos_inc   = {1'b0, pos_r} + 1'b1;
  // The row ends on this pixel once position plus one reaches the width. This
  // is a compare rather than an equality so that a width lowered mid-row still
  // closes the row on the next pixel.
  assign row_end   = pos_inc >= {1'b0, width_eff};

  // Pixels that do not close a row never touch the result register, so they
  // may pass while a result waits.
  assign in_ready  = !out_valid_r || out_ready || !row_end;
  assign in_acc    = in_valid && in_ready;

  assign cnt_last     = cnt_r - 1'b1;
  assign cnt_nxt_last = cnt_nxt - 1'b1;

  // Run tracking for one pixel. A falling edge of the pixel stream closes the
  // open run at the current position; a rising edge opens a new run while a
  // slot is free, and otherwise only marks the row as too curvy. On the last
  // pixel of a row a run that is still open is closed at the row edge.
  always_comb begin
    starts_nxt = starts_r;
    ends_nxt   = ends_r;
    cnt_nxt    = cnt_r;
    inside_nxt = inside_r;
    ovf_nxt    = ovf_r;
    if (inside_r && !in_pixel_bit) begin
      if (cnt_r != '0) begin
        ends_nxt[cnt_last[RIDX_W-1:0]] = pos_r;
      end
      inside_nxt = 1'b0;
    end else if (!inside_r && in_pixel_bit) begin
      if (cnt_r < CNT_W'(MAX_RUNS)) begin
        starts_nxt[cnt_r[RIDX_W-1:0]] = pos_r;
        cnt_nxt    = cnt_r + 1'b1;
        inside_nxt = 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (row_end && inside_nxt && (cnt_nxt != '0)) begin
      ends_nxt[cnt_nxt_last[RIDX_W-1:0]] = pos_inc[PIX_W-1:0];
    end
  end

  // Slot selection for the row result. Slots past the last run repeat it; a
  // blank row centers every slot on half the programmed width.
  always_comb begin
    for (int k = 0; k < OUT_SLOTS; k++) begin
      if (cnt_nxt == '0) begin
        slot_start_nxt[k] = width_r >> 1;
        slot_end_nxt[k]   = width_r >> 1;
      end else if (k < int'(cnt_nxt)) begin
        slot_start_nxt[k] = starts_nxt[RIDX_W'(k)];
        slot_end_nxt[k]   = ends_nxt[RIDX_W'(k)];
      end else begin
        slot_start_nxt[k] = starts_nxt[cnt_nxt_last[RIDX_W-1:0]];
        slot_end_nxt[k]   = ends_nxt[cnt_nxt_last[RIDX_W-1:0]];
      end
    end
  end

  // Control state: width, row counters and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= GLYPH_WIDTH_RST;
      pos_r       <= '0;
      cnt_r       <= '0;
      inside_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      if (in_acc) begin
        if (row_end) begin
          pos_r    <= '0;
          cnt_r    <= '0;
          inside_r <= 1'b0;
          ovf_r    <= 1'b0;
        end else begin
          pos_r    <= pos_inc[PIX_W-1:0];
          cnt_r    <= cnt_nxt;
          inside_r <= inside_nxt;
          ovf_r    <= ovf_nxt;
        end
      end
      if (in_acc && row_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: run coordinates and the result word. Run slots are always written
  // before they are read within a row, so they need no clearing.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      starts_r <= starts_nxt;
      ends_r   <= ends_nxt;
      if (row_end) begin
        slot_start_r <= slot_start_nxt;
        slot_end_r   <= slot_end_nxt;
        too_curvy_r  <= ovf_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_start_0   = slot_start_r[0];
  assign out_end_0     = slot_end_r[0];
  assign out_start_1   = slot_start_r[1];
  assign out_end_1     = slot_end_r[1];
  assign out_start_2   = slot_start_r[2];
  assign out_end_2     = slot_end_r[2];
  assign out_start_3   = slot_start_r[3];
  assign out_end_3     = slot_end_r[3];
  assign out_start_4   = slot_start_r[4];
  assign out_end_4     = slot_end_r[4];
  assign out_too_curvy = too_curvy_r;

  // The run counter never passes the number of slots.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RUNS))
    else $error("run counter above MAX_RUNS");

  // Being inside a run means at least one run was started.
  a_inside_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    inside_r |-> (cnt_r != '0))
    else $error("inside a run with no run recorded");

  // The overflow flag is only set once every slot is taken.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CNT_W'(MAX_RUNS)))
    else $error("too-curvy flag with free run slots");

  // A row end empties the row state.
  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && row_end) |=> (pos_r == '0) && (cnt_r == '0) && !inside_r && !ovf_r)
    else $error("row state not cleared after row end");

  // A result only appears after the last pixel of a row.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && row_end))
    else $error("result raised without a row end");

endmodule

FILE: sim/bitmap_row_span_extractor_test.sv
// Testbench for bitmap_row_span_extractor: drives pixel words, predicts each row word
// and checks every field. Depends on brse_pkg and the block's RTL only.
module bitmap_row_span_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brse_pkg::*;

  // The block takes one pixel per cycle while in_ready is high and registers
  // the row word at the edge that takes the last pixel.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Cycles without any accepted word before the run is declared hung.
  // The longest correct gap comes from a 79% stall on one side; this is far
  // above it.
  localparam int unsigned STALL_LIMIT = 1000;
  // Stop conditions for each random phase.
  localparam int unsigned PHASE_PIXELS = 64;
  localparam int unsigned PHASE_ROWS = 8;

  // One row word as the block presents it.
  typedef struct packed {
    logic [OUT_SLOTS-1:0][PIX_W-1:0] starts;
    logic [OUT_SLOTS-1:0][PIX_W-1:0] ends;
    logic                            too_curvy;
  } row_spans_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [PIX_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  logic             in_pixel_bit;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] out_start_0, out_end_0, out_start_1, out_end_1;
  logic [PIX_W-1:0] out_start_2, out_end_2, out_start_3, out_end_3;
  logic [PIX_W-1:0] out_start_4, out_end_4;
  logic             out_too_curvy;

  logic [OUT_SLOTS-1:0][PIX_W-1:0] got_starts;
  logic [OUT_SLOTS-1:0][PIX_W-1:0] got_ends;

  assign got_starts = {out_start_4, out_start_3, out_start_2, out_start_1, out_start_0};
  assign got_ends   = {out_end_4, out_end_3, out_end_2, out_end_1, out_end_0};

  bitmap_row_span_extractor u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_bit (in_pixel_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_start_0  (out_start_0),
    .out_end_0    (out_end_0),
    .out_start_1  (out_start_1),
    .out_end_1    (out_end_1),
    .out_start_2  (out_start_2),
    .out_end_2    (out_end_2),
    .out_start_3  (out_start_3),
    .out_end_3    (out_end_3),
    .out_start_4  (out_start_4),
    .out_end_4    (out_end_4),
    .out_too_curvy(out_too_curvy)
  );

  // Row words the predictor has produced and the block has not yet delivered.
  row_spans_t row_spans_due[$];
  row_spans_t want_word;

  // Predictor state: a private copy of the width register and the row tracker.
  logic [PIX_W-1:0] cur_width;
  int unsigned      row_pos;
  int unsigned      runs_seen;
  bit               in_span;
  logic [PIX_W-1:0] span_starts[MAX_RUNS_DEF];
  logic [PIX_W-1:0] span_ends[MAX_RUNS_DEF];
  bit               curvy_seen;

  int unsigned failures;
  int unsigned pixels_sent;
  int unsigned rows_predicted;
  int unsigned stall_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Empty the predicted row, as the block does after each row word.
  function automatic void clear_row_tracker();
    row_pos    = 0;
    runs_seen  = 0;
    in_span    = 1'b0;
    curvy_seen = 1'b0;
    for (int k = 0; k < MAX_RUNS_DEF; k++) begin
      span_starts[k] = '0;
      span_ends[k]   = '0;
    end
  endfunction

  // Advance the predicted row by one accepted pixel. When the pixel closes
  // the row, the expected row word is queued and the tracker starts over.
  function automatic void track_pixel(input logic pix);
    int unsigned eff_width;
    int unsigned next_pos;
    int unsigned idx;
    row_spans_t  word;

    // A width of zero behaves as a one pixel row.
    eff_width = (cur_width == 0) ? 1 : cur_width;
    next_pos  = row_pos + 1;

    if (in_span) begin
      if (!pix) begin
        span_ends[runs_seen-1] = row_pos[PIX_W-1:0];
        in_span = 1'b0;
      end
    end else if (pix) begin
      // A run beyond the last slot is not recorded; it only flags the row.
      if (runs_seen < MAX_RUNS_DEF) begin
        span_starts[runs_seen] = row_pos[PIX_W-1:0];
        runs_seen++;
        in_span = 1'b1;
      end else begin
        curvy_seen = 1'b1;
      end
    end

    // The row ends at the first pixel whose position plus one reaches the
    // width, which also covers a width lowered in the middle of a row.
    if (next_pos < eff_width) begin
      row_pos = next_pos;
    end else begin
      if (in_span) begin
        span_ends[runs_seen-1] = next_pos[PIX_W-1:0];
      end
      for (int k = 0; k < OUT_SLOTS; k++) begin
        if (runs_seen == 0) begin
          // A blank row reports the middle of the width register as it is now.
          word.starts[k] = cur_width >> 1;
          word.ends[k]   = cur_width >> 1;
        end else begin
          // Slots past the last run repeat the last run.
          idx = (k < runs_seen) ? k : runs_seen - 1;
          word.starts[k] = span_starts[idx];
          word.ends[k]   = span_ends[idx];
        end
      end
      word.too_curvy = curvy_seen;
      row_spans_due.push_back(word);
      rows_predicted++;
      clear_row_tracker();
    end
  endfunction

  // Offer one pixel word. Payload changes only at the falling edge and is
  // held with valid high until a rising edge sees ready.
  task automatic send_pixel(input logic pix);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_pixel_bit = pix;
    do begin
      @(posedge clk);
    end while (!in_ready);
    track_pixel(pix);
    pixels_sent++;
  endtask

  // Stop offering pixels, wait for every predicted row word, then let the
  // block settle. Every width write and the end of the test go through here.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (row_spans_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the width register while no pixel is in flight. The predictor
  // takes the new value at the same edge as the block.
  task automatic write_width(input logic [PIX_W-1:0] width);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = width;
    @(posedge clk);
    cur_width = width;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Send a stretch of pixels. Most stretches alternate runs and gaps of
  // random lengths so that rows fill several slots and often overflow;
  // the rest are blank, solid or plain noise.
  task automatic send_row_pattern(input int unsigned count);
    int unsigned mode;
    int unsigned left;
    int unsigned len;
    int unsigned max_len;
    logic        level;

    mode    = $urandom_range(9);
    level   = 1'($urandom_range(1));
    max_len = 1 + count / 8;
    left    = count;
    while (left > 0) begin
      if (mode >= 4) begin
        len = $urandom_range(1, max_len);
        if (len > left) begin
          len = left;
        end
        repeat (len) send_pixel(level);
        left  = left - len;
        level = ~level;
      end else begin
        case (mode)
          0: send_pixel(1'b0);
          1: send_pixel(1'b1);
          default: send_pixel(1'($urandom_range(1)));
        endcase
        left--;
      end
    end
  endtask

  // One row at the width the block comes out of reset with.
  task automatic test_reset_width();
    send_row_pattern(32'(GLYPH_WIDTH_RST));
  endtask

  // Width zero acts as one pixel per row and reports blank slots as zero.
  task automatic test_narrow_widths();
    write_width(8'd0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    write_width(8'd1);
    send_pixel(1'b1);
  endtask

  // Five runs fill every slot; the sixth set pixel only raises too_curvy.
  task automatic test_five_runs_and_overflow();
    write_width(8'd12);
    repeat (6) begin
      send_pixel(1'b1);
      send_pixel(1'b0);
    end
  endtask

  // A run that reaches the right edge ends at the width, and the unused
  // slots repeat it.
  task automatic test_run_to_edge();
    write_width(8'd6);
    send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b1);
  endtask

  // Lowering the width in the middle of a row ends it at the next pixel,
  // closing an open run there. The write also holds the sender until all
  // row words have come.
  task automatic test_width_change_mid_row();
    write_width(8'd6);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    write_width(8'd2);
    send_pixel(1'b1);
  endtask

  // Random rows under one idling mix. Each stretch picks a new width,
  // mostly narrow, and sometimes leaves a row unfinished so that the next
  // width write lands in the middle of a row.
  task automatic test_random_rows(input int unsigned sender_pct,
                                  input int unsigned receiver_pct);
    int unsigned pixels_at_start;
    int unsigned rows_at_start;
    int unsigned pick;
    int unsigned row_len;
    logic [PIX_W-1:0] width;

    send_idle_pct   = sender_pct;
    recv_idle_pct   = receiver_pct;
    pixels_at_start = pixels_sent;
    rows_at_start   = rows_predicted;
    while (pixels_sent - pixels_at_start < PHASE_PIXELS ||
           rows_predicted - rows_at_start < PHASE_ROWS) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        width = 8'd0;
      end else if (pick < 12) begin
        width = 8'd1;
      end else if (pick < 22) begin
        width = PIX_W'($urandom_range(17, 40));
      end else begin
        width = PIX_W'($urandom_range(2, 12));
      end
      write_width(width);
      row_len = (width == 0) ? 1 : width;
      repeat ($urandom_range(1, 4)) send_row_pattern(row_len);
      if (row_len > 1 && $urandom_range(99) < 30) begin
        send_row_pattern($urandom_range(1, row_len - 1));
      end
    end
  endtask

  // The widest row drives coordinates up to the top of their range.
  task automatic test_widest_row();
    write_width(8'd255);
    send_row_pattern(255);
  endtask

  // The receiver stalls at random; its share of idle cycles follows the phase.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each delivered row word with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (row_spans_due.size() == 0) begin
        $error("row word with no prediction waiting");
        failures++;
      end else begin
        want_word = row_spans_due.pop_front();
        for (int k = 0; k < OUT_SLOTS; k++) begin
          if (got_starts[k] !== want_word.starts[k]) begin
            $error("start_%0d: expected %0d, got %0d", k, want_word.starts[k],
                   got_starts[k]);
            failures++;
          end
          if (got_ends[k] !== want_word.ends[k]) begin
            $error("end_%0d: expected %0d, got %0d", k, want_word.ends[k],
                   got_ends[k]);
            failures++;
          end
        end
        if (out_too_curvy !== want_word.too_curvy) begin
          $error("too_curvy: expected %0d, got %0d", want_word.too_curvy,
                 out_too_curvy);
          failures++;
        end
      end
    end
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_pixel_bit   = 1'b0;
    failures       = 0;
    pixels_sent    = 0;
    rows_predicted = 0;
    stall_cycles   = 0;
    send_idle_pct  = 19;
    recv_idle_pct  = 79;
    cur_width      = GLYPH_WIDTH_RST;
    clear_row_tracker();

    // Synchronous reset, held low from the start and released once.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_width();
    test_narrow_widths();
    test_five_runs_and_overflow();
    test_run_to_edge();
    test_width_change_mid_row();
    test_random_rows(19, 79);
    test_random_rows(79, 19);
    test_random_rows(0, 0);
    test_widest_row();

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && row_spans_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: bitmap_row_span_extractor.f
sv/brse_pkg.sv
sv/bitmap_row_span_extractor.sv
sim/bitmap_row_span_extractor_test.sv
